@@ design/astlb_pkg.sv @@
// ----------------------------------------------------------------------------
// Translation buffer package
// Types, field positions, page masks and helper functions.
// ----------------------------------------------------------------------------
package astlb_pkg;

    localparam int ENTRIES    = 128;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int HINT_POS   = 5;
    localparam int GLOBAL_POS = 4;
    localparam int FAULT_POS  = 1;
    localparam int RIGHTS_POS = 8;
    localparam int PFN_SHIFT  = 19;
    localparam int VPN_W      = 35;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [2:0] {
        FUNC_TRANSLATE = 3'd0,
        FUNC_WRITE_TAG = 3'd1,
        FUNC_WRITE_PTE = 3'd2,
        FUNC_INV_ALL   = 3'd3,
        FUNC_INV_PROC  = 3'd4,
        FUNC_INV_ONE   = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_MISS   = 2'd1,
        ST_ACCESS = 2'd2,
        ST_FAULT  = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPERPAGE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ISIDE     = 1'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] operand;
        logic        tag_slot;
        logic [7:0]  current_asn;
        logic        access_kind;
        logic [1:0]  cpu_mode;
        logic        check_access;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] phys_addr;
        logic        global_page;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

    function automatic logic [VPN_W-1:0] vmask(input logic [1:0] hint);
        logic [VPN_W-1:0] m;
        begin
            m = '1;
            case (hint)
                2'd0:    m = '1;
                2'd1:    m = {{(VPN_W-3){1'b1}}, 3'b000};
                2'd2:    m = {{(VPN_W-6){1'b1}}, 6'b000000};
                default: m = {{(VPN_W-9){1'b1}}, 9'b000000000};
            endcase
            return m;
        end
    endfunction

endpackage

@@ design/astlb_if.sv @@
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface astlb_req_if;
    import astlb_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface astlb_rsp_if;
    import astlb_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ design/astlb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Translation buffer controller
// Sequences capture, execute and result transfer.
// ----------------------------------------------------------------------------
module astlb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output astlb_pkg::cmd_t   cmd
);
    import astlb_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready;
                if (out_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

@@ design/astlb_dp.sv @@
// ----------------------------------------------------------------------------
// Translation buffer datapath
// Entry array, parallel match, fill, invalidate and result register.
// ----------------------------------------------------------------------------
module astlb_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  astlb_pkg::cmd_t                     cmd,
    input  astlb_pkg::req_t                     req,
    input  logic [2:0]                          superpage_enable,
    input  logic                                instruction_side,
    output astlb_pkg::rsp_t                     rsp
);
    import astlb_pkg::*;

    req_t             req_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [VPN_W-1:0] vpage_reg  [ENTRIES];
    logic [VPN_W-1:0] ppage_reg  [ENTRIES];
    logic [1:0]       hint_reg   [ENTRIES];
    logic             global_reg [ENTRIES];
    logic [7:0]       asn_reg    [ENTRIES];
    logic [9:0]       rights_reg [ENTRIES];
    logic [IDX_W-1:0] fill_reg;
    logic [47:0]      tag_reg [2];
    rsp_t             rsp_reg;

    logic [47:0]        key;
    logic [ENTRIES-1:0] hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               any_hit;
    logic [63:0]        op;
    logic [1:0]         nhint;
    logic [VPN_W-1:0]   nmask;
    logic [63:0]        pa_raw;
    logic [9:0]         nrights;
    rsp_t               rsp_next;
    logic [47:0]        va;
    logic [VPN_W-1:0]   hm;
    logic [9:0]         hr;
    logic [2:0]         ri;

    assign op  = req_reg.operand;
    assign va  = op[47:0];
    assign key = (req_reg.func == FUNC_WRITE_PTE) ? tag_reg[req_reg.tag_slot] : va;

    always_comb
    begin
        for (int k = 0; k < ENTRIES; k++)
            hit[k] = valid_reg[k]
                && (((vpage_reg[k] ^ key[47:13]) & vmask(hint_reg[k])) == '0)
                && (global_reg[k] || asn_reg[k] == req_reg.current_asn);
    end

    always_comb
    begin
        hit_idx = '0;
        any_hit = 1'b0;
        for (int k = ENTRIES - 1; k >= 0; k--)
            if (hit[k])
            begin
                hit_idx = IDX_W'(k);
                any_hit = 1'b1;
            end
    end

    assign nhint  = op[HINT_POS +: 2];
    assign nmask  = vmask(nhint);
    assign pa_raw = instruction_side ? op : (op >> PFN_SHIFT);
    always_comb
    begin
        nrights = '0;
        if (instruction_side)
            nrights[3:0] = op[RIGHTS_POS +: 4];
        else
            nrights = {op[FAULT_POS + 1], op[FAULT_POS], op[RIGHTS_POS +: 8]};
    end

    assign hm = vmask(hint_reg[hit_idx]);
    assign hr = rights_reg[hit_idx];
    assign ri = {req_reg.access_kind, req_reg.cpu_mode};

    always_comb
    begin
        rsp_next = '0;
        if (req_reg.func == FUNC_TRANSLATE)
        begin
            if (req_reg.cpu_mode == 2'd0 && superpage_enable[2] && va[47:46] == 2'b10)
                rsp_next.phys_addr = {4'd0, va[43:0]};
            else if (req_reg.cpu_mode == 2'd0 && superpage_enable[1]
                     && va[47:41] == 7'h7e)
                rsp_next.phys_addr = {5'd0, va[40], va[40], va[40:0]};
            else if (req_reg.cpu_mode == 2'd0 && superpage_enable[0]
                     && va[47:30] == 18'h3fffe)
                rsp_next.phys_addr = {18'd0, va[29:0]};
            else if (!any_hit)
                rsp_next.status = ST_MISS;
            else if (req_reg.check_access && !hr[ri])
                rsp_next.status = ST_ACCESS;
            else if (req_reg.check_access && hr[8 + {3'd0, req_reg.access_kind}])
                rsp_next.status = ST_FAULT;
            else
            begin
                rsp_next.phys_addr = {(ppage_reg[hit_idx] & hm) | (va[47:13] & ~hm),
                                      va[12:0]};
                rsp_next.global_page = global_reg[hit_idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.exec)
            rsp_reg <= rsp_next;
        if (cmd.exec && req_reg.func == FUNC_WRITE_PTE && !any_hit)
        begin
            vpage_reg[fill_reg]  <= tag_reg[req_reg.tag_slot][47:13] & nmask;
            ppage_reg[fill_reg]  <= pa_raw[47:13] & nmask;
            hint_reg[fill_reg]   <= nhint;
            global_reg[fill_reg] <= op[GLOBAL_POS];
            asn_reg[fill_reg]    <= req_reg.current_asn;
            rights_reg[fill_reg] <= nrights;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            tag_reg[0] <= '0;
            tag_reg[1] <= '0;
        end
        else if (cmd.exec)
        begin
            case (req_reg.func)
                FUNC_WRITE_TAG: tag_reg[req_reg.tag_slot] <= va;
                FUNC_WRITE_PTE:
                begin
                    if (!any_hit)
                    begin
                        valid_reg[fill_reg] <= 1'b1;
                        fill_reg <= (fill_reg == IDX_W'(ENTRIES - 1)) ? '0 : fill_reg + 1'b1;
                    end
                end
                FUNC_INV_ALL: valid_reg <= '0;
                FUNC_INV_PROC:
                begin
                    for (int k = 0; k < ENTRIES; k++)
                        if (!global_reg[k])
                            valid_reg[k] <= 1'b0;
                end
                FUNC_INV_ONE: valid_reg <= valid_reg & ~hit;
                default: ;
            endcase
        end
    end

    assign rsp = rsp_reg;
endmodule

@@ design/alpha_style_tlb_translate_top.sv @@
// ----------------------------------------------------------------------------
// Translation buffer top level
// Fully associative TLB with granularity hint and superpage windows.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation per transfer (translate, tag write, PTE write,
//   or one of three invalidates); rsp returns exactly one result per request.
//   cfg_we/cfg_idx/cfg_data write superpage_enable (0) and instruction_side
//   (1); write only while the block is idle.
// Sequence: request captured at the accepting edge, evaluated in the next
//   cycle against all entries in parallel, result registered; rsp is valid
//   once the controller reaches its output state with the result loaded.
// Overlap: a new request is taken only while idle or as the previous
//   result transfers, so one request is never evaluated behind another.
// Reset: all entries invalid, fill pointer and tag holding registers zero,
//   both configuration registers zero.
// Stall: while rsp is held the result stays in its register; the next
//   request is taken in the cycle its result transfers.
// ----------------------------------------------------------------------------
module alpha_style_tlb_translate_top (
    input  logic                               clk,
    input  logic                               rst_n,
    astlb_req_if.sink                          req,
    astlb_rsp_if.source                        rsp,
    input  logic                               cfg_we,
    input  logic [astlb_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [astlb_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import astlb_pkg::*;

    cmd_t       cmd;
    logic [2:0] sp_reg;
    logic       iside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg    <= '0;
            iside_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_SUPERPAGE: sp_reg    <= cfg_data;
                CFG_ISIDE:     iside_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    astlb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    astlb_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .req              (req.data),
        .superpage_enable (sp_reg),
        .instruction_side (iside_reg),
        .rsp              (rsp.data)
    );
endmodule

@@ design/astlb_checker.sv @@
// ----------------------------------------------------------------------------
// Translation buffer checker
// Port-level properties of the request/result sequence.
// ----------------------------------------------------------------------------
module astlb_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input astlb_pkg::rsp_t   rsp_data
);
    import astlb_pkg::*;

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !rsp_valid ##1 rsp_valid)
        else $error("result not two cycles after request");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != ST_OK |->
            rsp_data.phys_addr == '0 && !rsp_data.global_page)
        else $error("non-ok result carries data");

    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |-> !req_ready)
        else $error("request taken while result held");
endmodule

bind alpha_style_tlb_translate_top astlb_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

@@ tb/sv/alpha_style_tlb_translate_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Translation buffer testbench
// Drives operation streams through the TLB with random gaps on both sides,
// predicts every result with a behavioural copy of the buffer state and
// checks each response field in order.
// ----------------------------------------------------------------------------
module alpha_style_tlb_translate_top_tb;
    import astlb_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    astlb_req_if req_ch ();
    astlb_rsp_if rsp_ch ();

    alpha_style_tlb_translate_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch.sink),
        .rsp      (rsp_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    localparam logic [47:0] MASK0 = 48'hffffffffe000;
    localparam logic [47:0] MASK1 = 48'hffffffff0000;
    localparam logic [47:0] MASK2 = 48'hfffffff80000;
    localparam logic [47:0] MASK3 = 48'hffffffc00000;

    logic [2:0]  spe;
    logic        iside;
    logic        tv_valid [ENTRIES];
    logic [47:0] tv_vbase [ENTRIES];
    logic [47:0] tv_pbase [ENTRIES];
    logic [1:0]  tv_hint  [ENTRIES];
    logic        tv_glob  [ENTRIES];
    logic [7:0]  tv_asn   [ENTRIES];
    logic [9:0]  tv_rights[ENTRIES];
    int          fill_ptr;
    logic [47:0] tag_reg [2];

    req_t pending_ops[$];
    rsp_t expected_rsp[$];
    int   errors;
    int   n_rsp;
    int   n_hits;
    bit   stim_done;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [47:0] page_mask(input logic [1:0] h);
        case (h)
            2'd0:    return MASK0;
            2'd1:    return MASK1;
            2'd2:    return MASK2;
            default: return MASK3;
        endcase
    endfunction

    function automatic int find_entry(input logic [47:0] va, input logic [7:0] asn);
        for (int k = 0; k < ENTRIES; k++)
            if (tv_valid[k] && (((tv_vbase[k] ^ va) & page_mask(tv_hint[k])) == 0)
                && (tv_glob[k] || tv_asn[k] == asn))
                return k;
        return -1;
    endfunction

    function automatic rsp_t translate_op(input req_t r);
        rsp_t o;
        logic [47:0] va;
        logic [47:0] m;
        int k;
        o = '0;
        va = r.operand[47:0];
        if (spe != 0 && r.cpu_mode == 2'd0)
        begin
            if (va[47:46] == 2'd2 && spe[2])
            begin
                o.phys_addr = {4'd0, va[43:0]};
                return o;
            end
            if (va[47:41] == 7'h7e && spe[1])
            begin
                o.phys_addr = {5'd0, va[40], va[40], va[40:0]};
                return o;
            end
            if (va[47:30] == 18'h3fffe && spe[0])
            begin
                o.phys_addr = {18'd0, va[29:0]};
                return o;
            end
        end
        k = find_entry(va, r.current_asn);
        if (k < 0)
        begin
            o.status = ST_MISS;
            return o;
        end
        if (r.check_access)
        begin
            if (!tv_rights[k][r.access_kind * 4 + r.cpu_mode])
            begin
                o.status = ST_ACCESS;
                return o;
            end
            if (tv_rights[k][8 + r.access_kind])
            begin
                o.status = ST_FAULT;
                return o;
            end
        end
        m = page_mask(tv_hint[k]);
        o.phys_addr = (tv_pbase[k] & m) | (va & ~m);
        o.global_page = tv_glob[k];
        return o;
    endfunction

    function automatic rsp_t tlb_step(input req_t r);
        rsp_t o;
        logic [63:0] p;
        logic [47:0] m;
        logic [9:0] rt;
        int k;
        o = '0;
        p = r.operand;
        case (r.func)
            FUNC_TRANSLATE: o = translate_op(r);
            FUNC_WRITE_TAG: tag_reg[r.tag_slot] = p[47:0];
            FUNC_WRITE_PTE:
            begin
                if (find_entry(tag_reg[r.tag_slot], r.current_asn) < 0)
                begin
                    k = fill_ptr;
                    tv_hint[k] = p[HINT_POS +: 2];
                    m = page_mask(p[HINT_POS +: 2]);
                    rt = '0;
                    if (iside)
                    begin
                        tv_pbase[k] = p[47:0] & m;
                        rt[3:0] = p[RIGHTS_POS +: 4];
                    end
                    else
                    begin
                        tv_pbase[k] = 48'((p >> PFN_SHIFT) & {16'd0, m});
                        rt[7:0] = p[RIGHTS_POS +: 8];
                        rt[8] = p[FAULT_POS];
                        rt[9] = p[FAULT_POS + 1];
                    end
                    tv_vbase[k] = tag_reg[r.tag_slot] & m;
                    tv_rights[k] = rt;
                    tv_glob[k] = p[GLOBAL_POS];
                    tv_asn[k] = r.current_asn;
                    tv_valid[k] = 1'b1;
                    fill_ptr = (k + 1) % ENTRIES;
                end
            end
            FUNC_INV_ALL:
                for (int j = 0; j < ENTRIES; j++)
                    tv_valid[j] = 1'b0;
            FUNC_INV_PROC:
                for (int j = 0; j < ENTRIES; j++)
                    if (!tv_glob[j])
                        tv_valid[j] = 1'b0;
            FUNC_INV_ONE:
            begin
                k = find_entry(p[47:0], r.current_asn);
                while (k >= 0)
                begin
                    tv_valid[k] = 1'b0;
                    k = find_entry(p[47:0], r.current_asn);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int gap_len();
        int c;
        c = $urandom_range(0, 99);
        if (c < 40)
            return 0;
        if (c < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    int req_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            req_gap = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsp.push_back(tlb_step(req_ch.data));
                void'(pending_ops.pop_front());
                req_gap = gap_len();
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (req_gap > 0 || pending_ops.size() == 0)
                begin
                    if (req_gap > 0)
                        req_gap--;
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_ops[0];
                end
            end
        end
    end

    int rsp_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_gap = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_rsp++;
                if (expected_rsp.size() == 0)
                    report("response with nothing expected", rsp_ch.data, '0);
                else
                begin
                    rsp_t e;
                    e = expected_rsp.pop_front();
                    if (e.status == ST_OK && e.phys_addr != 0)
                        n_hits++;
                    if (rsp_ch.data !== e)
                        report("field mismatch", rsp_ch.data, e);
                end
            end
            if (rsp_gap > 0)
            begin
                rsp_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rsp_gap = gap_len();
            end
        end
    end

    task automatic report(input string what, input rsp_t got, input rsp_t exp);
        errors++;
        if (errors <= 30)
            $display("%0t mismatch (%s): status %0d/%0d pa %h/%h global %0d/%0d",
                     $realtime, what, got.status, exp.status, got.phys_addr,
                     exp.phys_addr, got.global_page, exp.global_page);
    endtask

    function automatic req_t make_op(input func_t f, input logic [63:0] opnd,
                                     input logic sl, input logic [7:0] asn);
        req_t r;
        r.func = f;
        r.operand = opnd;
        r.tag_slot = sl;
        r.current_asn = asn;
        r.access_kind = 1'($urandom_range(0, 1));
        r.cpu_mode = 2'($urandom_range(0, 3));
        r.check_access = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic drain();
        while (pending_ops.size() != 0 || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [2:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SUPERPAGE)
            spe = v;
        else
            iside = v[0];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // virtual addresses drawn from a small pool so that lookups hit
    logic [47:0] va_pool [16];

    function automatic logic [63:0] pick_va();
        logic [63:0] v;
        v = rand64();
        case ($urandom_range(0, 5))
            0: ;
            1: v[47:46] = 2'd2;
            2: v[47:41] = 7'h7e;
            3: v[47:30] = 18'h3fffe;
            default: v[47:0] = va_pool[$urandom_range(0, 15)] ^ {35'd0, v[12:0]}
                               ^ ($urandom_range(0, 3) == 0 ? {26'd0, v[21:0]} : 48'd0);
        endcase
        return v;
    endfunction

    task automatic random_phase(input int n);
        req_t r;
        logic [63:0] pte;
        logic [7:0] asn;
        for (int i = 0; i < n; i++)
        begin
            asn = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 2));
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8:
                    r = make_op(FUNC_TRANSLATE, pick_va(), 1'b0, asn);
                9, 10:
                    r = make_op(FUNC_WRITE_TAG, {$urandom(), $urandom()} & 64'hffff000000000000
                        | {16'($urandom()), va_pool[$urandom_range(0, 15)]},
                        1'($urandom_range(0, 1)), asn);
                11, 12, 13:
                begin
                    pte = rand64();
                    if ($urandom_range(0, 1))
                        pte[RIGHTS_POS +: 8] = 8'hff;
                    if ($urandom_range(0, 1))
                        pte[FAULT_POS +: 2] = 2'b00;
                    r = make_op(FUNC_WRITE_PTE, pte, 1'($urandom_range(0, 1)), asn);
                end
                14:
                    r = make_op(FUNC_INV_ONE, pick_va(), 1'b0, asn);
                15:
                    r = make_op($urandom_range(0, 7) == 0 ? FUNC_INV_ALL : FUNC_INV_PROC,
                                rand64(), 1'b0, asn);
                16:
                begin
                    r = make_op(FUNC_TRANSLATE, rand64(), 1'b0, asn);
                    r.func = 3'($urandom_range(6, 7));
                end
                default:
                begin
                    r = make_op(FUNC_TRANSLATE, rand64(), 1'($urandom_range(0, 1)),
                                8'($urandom()));
                    r.func = 3'($urandom_range(0, 5));
                end
            endcase
            pending_ops.push_back(r);
        end
    endtask

    initial
    begin
        req_t r;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        errors = 0;
        n_rsp = 0;
        n_hits = 0;
        stim_done = 0;
        spe = 0;
        iside = 0;
        fill_ptr = 0;
        tag_reg[0] = '0;
        tag_reg[1] = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            tv_valid[k] = 1'b0;
            tv_vbase[k] = '0;
            tv_pbase[k] = '0;
            tv_hint[k] = '0;
            tv_glob[k] = '0;
            tv_asn[k] = '0;
            tv_rights[k] = '0;
        end
        for (int k = 0; k < 16; k++)
            va_pool[k] = 48'(rand64());
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: superpage windows, miss on empty, tag/PTE fill, hint sizes, checks, invalidates
        write_reg(CFG_SUPERPAGE, 3'd7);
        pending_ops.push_back(make_op(FUNC_TRANSLATE, 64'hffff_8000_0000_1234, 1'b0, 8'd0));
        pending_ops.push_back(make_op(FUNC_TRANSLATE, 64'h0000_fc00_0000_0000, 1'b0, 8'd0));
        pending_ops.push_back(make_op(FUNC_TRANSLATE, 64'h0000_fffe_0000_0000, 1'b0, 8'd0));
        pending_ops.push_back(make_op(FUNC_TRANSLATE, 64'hffff_ffff_ffff_ffff, 1'b0, 8'hff));
        for (int h = 0; h < 4; h++)
        begin
            pending_ops.push_back(make_op(FUNC_WRITE_TAG, {16'hffff, va_pool[h]}, h[0], 8'd0));
            pending_ops.push_back(make_op(FUNC_WRITE_PTE,
                {64'hffff_ffff_ffff_0000} | 64'(h << HINT_POS) | (64'(h[0]) << GLOBAL_POS)
                | (h == 3 ? 64'h6 : 64'h0), h[0], 8'hff));
            r = make_op(FUNC_TRANSLATE, {16'h0, va_pool[h]}, 1'b0, 8'h00);
            r.check_access = 1'b1;
            pending_ops.push_back(r);
        end
        pending_ops.push_back(make_op(FUNC_WRITE_PTE, 64'h0, 1'b1, 8'hff));
        pending_ops.push_back(make_op(FUNC_INV_ONE, {16'h0, va_pool[1]}, 1'b0, 8'hff));
        pending_ops.push_back(make_op(FUNC_INV_PROC, 64'h0, 1'b0, 8'd0));
        pending_ops.push_back(make_op(FUNC_TRANSLATE, {16'h0, va_pool[0]}, 1'b0, 8'hff));
        pending_ops.push_back(make_op(FUNC_INV_ALL, 64'h0, 1'b0, 8'd0));
        drain();

        write_reg(CFG_SUPERPAGE, 3'd0);
        random_phase(250);
        drain();
        write_reg(CFG_ISIDE, 3'd1);
        write_reg(CFG_SUPERPAGE, 3'($urandom_range(1, 6)));
        random_phase(200);
        drain();
        write_reg(CFG_ISIDE, 3'd0);
        write_reg(CFG_SUPERPAGE, 3'd7);
        random_phase(250);
        drain();
        write_reg(CFG_SUPERPAGE, 3'($urandom_range(0, 7)));
        write_reg(CFG_ISIDE, 3'($urandom_range(0, 1)));
        random_phase(200);
        drain();

        $display("Ran %0d operations across five register settings; %0d mapped translations.",
                 n_rsp, n_hits);
        if (errors == 0)
            $display("[alpha_style_tlb_translate_top] OK");
        else
            $display("[alpha_style_tlb_translate_top] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[alpha_style_tlb_translate_top] ERROR");
        $finish;
    end

endmodule
